// ----- rtl/psvp_pkg.sv -----
// Package: shared constants and pipeline types for the positional volume/pan block.
package psvp_pkg;

    localparam int          SQRT_CELLS  = 16;
    localparam logic [15:0] MAX_DIST    = 16'd512;
    localparam logic [7:0]  FULL_LEVEL  = 8'd128;
    localparam logic [31:0] RECIP_11    = 32'hBA2E_8BA3;
    localparam int          RECIP_SHIFT = 35;
    localparam int          VOL_W       = 29;
    localparam int          PAN_W       = 23;
    localparam int          DIST_W      = 16;

    typedef struct packed {
        logic [31:0] snd;
        logic [31:0] hd;
    } t_side;

    typedef struct packed {
        logic        valid;
        logic [31:0] v;
        logic [31:0] res;
        t_side       side;
    } t_sq;

endpackage

// ----- rtl/psvp_if.sv -----
// Interfaces: input item, result item and configuration write channels.
interface psvp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sound_number;
    logic [31:0] ear_x;
    logic [31:0] ear_y;
    logic [31:0] src_x;
    logic [31:0] src_y;

    modport source (output valid, sound_number, ear_x, ear_y, src_x, src_y, input ready);
    modport sink   (input valid, sound_number, ear_x, ear_y, src_x, src_y, output ready);
endinterface

interface psvp_out_if
    import psvp_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [31:0]       sound_out;
    logic              audible;
    logic [DIST_W-1:0] distance;
    logic [VOL_W-1:0]  volume;
    logic [PAN_W-1:0]  pan;

    modport source (output valid, sound_out, audible, distance, volume, pan, input ready);
    modport sink   (input valid, sound_out, audible, distance, volume, pan, output ready);
endinterface

interface psvp_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] master_gain;

    modport source (output valid, master_gain, input ready);
    modport sink   (input valid, master_gain, output ready);
endinterface

// ----- rtl/psvp_sqrt_cell.sv -----
// Square root cell: one digit-by-digit iteration, registered, hands off to the next cell.
module psvp_sqrt_cell
    import psvp_pkg::*;
#(
    parameter int K = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_en,
    input  t_sq  i_sq,
    output t_sq  o_sq
);

    localparam logic [31:0] BIT = 32'd1 << (30 - 2 * K);

    t_sq         r_sq;
    t_sq         n_sq;
    logic [31:0] trial;

    always_comb begin
        n_sq  = i_sq;
        trial = i_sq.res + BIT;
        if (i_sq.v >= trial) begin
            n_sq.v   = i_sq.v - trial;
            n_sq.res = (i_sq.res >> 1) + BIT;
        end else begin
            n_sq.res = i_sq.res >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq.valid <= 1'b0;
        end else if (i_en) begin
            r_sq <= n_sq;
        end
    end

    assign o_sq = r_sq;

endmodule

// ----- rtl/positional_sound_volume_pan.sv -----
// Top level: positional sound distance, volume and pan pipeline.
// Accepts one item per clock while the result is not held and returns one result per
// item, in order. The square root is a row of 16 cells, one result bit each, behind
// three stages for the differences, squares and sum, and followed by four stages for
// the level product, the magnitude and pan, the divide by eleven and the output
// register. When the result is held, the whole pipeline holds with it. Writes of
// master_gain are taken in any cycle and apply to items that reach the level stage after.
module positional_sound_volume_pan
    import psvp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    psvp_in_if.sink    i_in,
    psvp_cfg_if.sink   i_cfg,
    psvp_out_if.source o_out
);

    logic        en;
    logic [31:0] r_mix;

    // stage a: differences
    logic        r_a_valid;
    logic [31:0] r_a_dx;
    logic [31:0] r_a_dy;
    t_side       r_a_side;

    // stage b: squares
    logic        r_b_valid;
    logic [31:0] r_b_sqx;
    logic [31:0] r_b_sqy;
    t_side       r_b_side;

    // stage c: radicand
    t_sq         r_c_sq;
    logic [31:0] sum;

    t_sq         chain [SQRT_CELLS+1];

    // stage d: level product
    logic              r_d_valid;
    logic [31:0]       r_d_snd;
    logic [DIST_W-1:0] r_d_dist;
    logic              r_d_aud;
    logic [31:0]       r_d_prod;
    logic [31:0]       r_d_hd;
    logic [DIST_W-1:0] d_dist;
    logic [7:0]        d_remain;

    // stage e: magnitude and pan
    logic              r_e_valid;
    logic [31:0]       r_e_snd;
    logic [DIST_W-1:0] r_e_dist;
    logic              r_e_aud;
    logic              r_e_neg;
    logic [31:0]       r_e_mag;
    logic [PAN_W-1:0]  r_e_pan;
    logic [31:0]       e_pan_full;

    // stage f: divide by eleven
    logic              r_f_valid;
    logic [31:0]       r_f_snd;
    logic [DIST_W-1:0] r_f_dist;
    logic              r_f_aud;
    logic              r_f_neg;
    logic [VOL_W-1:0]  r_f_q;
    logic [PAN_W-1:0]  r_f_pan;
    logic [63:0]       f_prod;

    // output register
    logic              r_o_valid;
    logic [31:0]       r_o_snd;
    logic              r_o_aud;
    logic [DIST_W-1:0] r_o_dist;
    logic [VOL_W-1:0]  r_o_vol;
    logic [PAN_W-1:0]  r_o_pan;

    assign en          = !r_o_valid || o_out.ready;
    assign i_in.ready  = en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mix <= '0;
        end else if (i_cfg.valid) begin
            r_mix <= i_cfg.master_gain;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_sq.valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_a_valid    <= i_in.valid;
            r_b_valid    <= r_a_valid;
            r_c_sq       <= '{valid: r_b_valid, v: (sum[31] ? 32'd0 : sum), res: '0,
                              side: r_b_side};
            r_d_valid    <= chain[SQRT_CELLS].valid;
            r_e_valid    <= r_d_valid;
            r_f_valid    <= r_e_valid;
            r_o_valid    <= r_f_valid;
        end
    end

    assign sum = r_b_sqx + r_b_sqy;

    always_comb begin
        d_dist   = chain[SQRT_CELLS].res[DIST_W-1:0];
        d_remain = FULL_LEVEL - {1'b0, d_dist[8:2]};
    end

    assign e_pan_full = 32'($signed(r_d_hd) + $signed(r_d_hd[31] ? 32'd511 : 32'd0)) >>> 9;
    assign f_prod     = 64'(r_e_mag) * 64'(RECIP_11);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_dx       <= i_in.ear_x - i_in.src_x;
            r_a_dy       <= i_in.ear_y - i_in.src_y;
            r_a_side.snd <= i_in.sound_number;
            r_a_side.hd  <= (i_in.src_x - i_in.ear_x) << 6;

            r_b_sqx  <= 32'(r_a_dx * r_a_dx);
            r_b_sqy  <= 32'(r_a_dy * r_a_dy);
            r_b_side <= r_a_side;

            r_d_snd  <= chain[SQRT_CELLS].side.snd;
            r_d_hd   <= chain[SQRT_CELLS].side.hd;
            r_d_dist <= d_dist;
            r_d_aud  <= d_dist < MAX_DIST;
            r_d_prod <= 32'(32'(d_remain) * r_mix);

            r_e_snd  <= r_d_snd;
            r_e_dist <= r_d_dist;
            r_e_aud  <= r_d_aud;
            r_e_neg  <= r_d_prod[31];
            r_e_mag  <= r_d_prod[31] ? (32'd0 - r_d_prod) : r_d_prod;
            r_e_pan  <= r_d_aud ? e_pan_full[PAN_W-1:0] : '0;

            r_f_snd  <= r_e_snd;
            r_f_dist <= r_e_dist;
            r_f_aud  <= r_e_aud;
            r_f_neg  <= r_e_neg;
            r_f_q    <= f_prod[RECIP_SHIFT +: VOL_W];
            r_f_pan  <= r_e_pan;

            r_o_snd  <= r_f_snd;
            r_o_aud  <= r_f_aud;
            r_o_dist <= r_f_dist;
            r_o_pan  <= r_f_pan;
            if (!r_f_aud) begin
                r_o_vol <= '0;
            end else if (r_f_neg) begin
                r_o_vol <= VOL_W'(0) - r_f_q;
            end else begin
                r_o_vol <= r_f_q;
            end
        end
    end

    assign chain[0] = r_c_sq;

    for (genvar k = 0; k < SQRT_CELLS; k++) begin : g_cell
        psvp_sqrt_cell #(
            .K (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_sq    (chain[k]),
            .o_sq    (chain[k+1])
        );
    end

    assign o_out.valid     = r_o_valid;
    assign o_out.sound_out = r_o_snd;
    assign o_out.audible   = r_o_aud;
    assign o_out.distance  = r_o_dist;
    assign o_out.volume    = r_o_vol;
    assign o_out.pan       = r_o_pan;

endmodule

// ----- tb/positional_sound_volume_pan_tb.sv -----
// Testbench: positional sound distance, volume and pan block against a cycle-free predictor.
module positional_sound_volume_pan_tb
    import psvp_pkg::*;
();

    localparam int CYCLE_LIMIT = 400_000;
    localparam int DRAIN       = 30;

    typedef struct packed {
        logic [31:0] snd;
        logic [31:0] lx;
        logic [31:0] ly;
        logic [31:0] tx;
        logic [31:0] ty;
    } t_voice;

    typedef struct packed {
        logic [31:0]       sound_out;
        logic              audible;
        logic [DIST_W-1:0] distance;
        logic [VOL_W-1:0]  volume;
        logic [PAN_W-1:0]  pan;
    } t_voice_mix;

    logic i_clk;
    logic i_rst_n;

    psvp_in_if  in_if();
    psvp_cfg_if cfg_if();
    psvp_out_if out_if();

    positional_sound_volume_pan dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    t_voice      voice_q[$];
    t_voice_mix  due_mixes[$];
    logic [31:0] mix_shadow;
    int          cfg_writes;
    int          cycles;
    bit          failed;
    bit          in_busy;
    bit          in_taken;
    bit          out_taken;
    bit          in_calm;
    bit          out_calm;
    int          in_gap;
    int          out_stall;

    initial begin
        i_clk = 1'b0;
    end

    always #5 i_clk = ~i_clk;

    function automatic t_voice_mix predict_voice(t_voice v, logic [31:0] level);
        t_voice_mix  r;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [31:0] sq;
        logic [31:0] remain;
        logic [31:0] prod;
        logic [31:0] hd;
        logic [15:0] root;
        logic [63:0] trial;
        int          vq;
        int          pq;
        dx   = v.lx - v.tx;
        dy   = v.ly - v.ty;
        sq   = dx * dx + dy * dy;
        root = '0;
        if (!sq[31]) begin
            for (int b = 15; b >= 0; b--) begin
                trial = {48'b0, root | (16'd1 << b)};
                if (trial * trial <= {32'b0, sq})
                    root = root | (16'd1 << b);
            end
        end
        r           = '0;
        r.sound_out = v.snd;
        r.distance  = root;
        if (root < MAX_DIST) begin
            remain    = 32'd128 - (({16'b0, root} << 7) / 32'd512);
            prod      = remain * level;
            hd        = (v.tx - v.lx) << 6;
            vq        = $signed(prod) / 11;
            pq        = $signed(hd) / 512;
            r.audible = 1'b1;
            r.volume  = vq[VOL_W-1:0];
            r.pan     = pq[PAN_W-1:0];
        end
        return r;
    endfunction

    function automatic t_voice random_voice();
        t_voice      v;
        int          kind;
        logic [31:0] ox;
        logic [31:0] oy;
        v.snd = $urandom();
        v.lx  = $urandom();
        v.ly  = $urandom();
        kind  = $urandom_range(0, 99);
        if (kind < 60) begin
            ox = $urandom_range(0, 1400) - 700;
            oy = $urandom_range(0, 1400) - 700;
        end else if (kind < 75) begin
            if ($urandom_range(0, 1)) begin
                ox = $urandom_range(355, 370);
                oy = $urandom_range(355, 370);
            end else begin
                ox = $urandom_range(505, 520);
                oy = $urandom_range(0, 3);
            end
        end else if (kind < 90) begin
            ox = $urandom() >> $urandom_range(5, 31);
            oy = $urandom() >> $urandom_range(5, 31);
        end else begin
            ox = $urandom();
            oy = $urandom();
        end
        if (kind < 90 && $urandom_range(0, 1))
            ox = -ox;
        if (kind < 90 && $urandom_range(0, 1))
            oy = -oy;
        v.tx = v.lx + ox;
        v.ty = v.ly + oy;
        return v;
    endfunction

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 29) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic void queue_voice(logic [31:0] snd, logic [31:0] lx, logic [31:0] ly,
                                        logic [31:0] tx, logic [31:0] ty);
        t_voice v;
        v = '{snd: snd, lx: lx, ly: ly, tx: tx, ty: ty};
        voice_q.push_back(v);
    endfunction

    task automatic wait_idle();
        while (voice_q.size() != 0 || in_busy || due_mixes.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN) @(negedge i_clk);
    endtask

    task automatic set_mix(input logic [31:0] level);
        int seen;
        seen = cfg_writes;
        cfg_if.master_gain <= level;
        cfg_if.valid       <= 1'b1;
        do @(negedge i_clk); while (cfg_writes == seen);
        cfg_if.valid <= 1'b0;
    endtask

    // input driver
    always @(negedge i_clk) begin
        t_voice cur;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else begin
            if (in_busy && in_taken)
                in_busy = 1'b0;
            if (!in_busy) begin
                if (in_gap > 0) begin
                    in_gap--;
                end else if (voice_q.size() != 0) begin
                    cur                = voice_q.pop_front();
                    in_busy            = 1'b1;
                    in_gap             = draw_wait(in_calm);
                    in_if.sound_number <= cur.snd;
                    in_if.ear_x        <= cur.lx;
                    in_if.ear_y        <= cur.ly;
                    in_if.src_x        <= cur.tx;
                    in_if.src_y        <= cur.ty;
                end
            end
            in_if.valid <= in_busy;
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_taken)
                out_stall = draw_wait(out_calm);
            if (out_stall > 0) begin
                out_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    // monitor: config shadow, predictions and result checks
    always @(posedge i_clk) begin
        t_voice_mix want;
        t_voice     got_in;
        if (i_rst_n) begin
            if (out_if.valid && out_if.ready) begin
                if (due_mixes.size() == 0) begin
                    $error("unexpected result transfer, sound_out %0h", out_if.sound_out);
                    failed = 1'b1;
                end else begin
                    want = due_mixes.pop_front();
                    if (out_if.sound_out !== want.sound_out) begin
                        $error("sound_out expected %0h actual %0h", want.sound_out,
                               out_if.sound_out);
                        failed = 1'b1;
                    end
                    if (out_if.audible !== want.audible) begin
                        $error("audible expected %0b actual %0b", want.audible, out_if.audible);
                        failed = 1'b1;
                    end
                    if (out_if.distance !== want.distance) begin
                        $error("distance expected %0d actual %0d", want.distance,
                               out_if.distance);
                        failed = 1'b1;
                    end
                    if (out_if.volume !== want.volume) begin
                        $error("volume expected %0h actual %0h", want.volume, out_if.volume);
                        failed = 1'b1;
                    end
                    if (out_if.pan !== want.pan) begin
                        $error("pan expected %0h actual %0h", want.pan, out_if.pan);
                        failed = 1'b1;
                    end
                end
            end
            if (cfg_if.valid && cfg_if.ready) begin
                mix_shadow = cfg_if.master_gain;
                cfg_writes++;
            end
            if (in_if.valid && in_if.ready) begin
                got_in = '{snd: in_if.sound_number, lx: in_if.ear_x,
                           ly: in_if.ear_y, tx: in_if.src_x, ty: in_if.src_y};
                due_mixes.push_back(predict_voice(got_in, mix_shadow));
            end
        end
        in_taken  <= i_rst_n && in_if.valid && in_if.ready;
        out_taken <= i_rst_n && out_if.valid && out_if.ready;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        logic [31:0] levels[7];
        levels = '{32'h8000_0000, 32'hFFFF_FFFF, 32'd1, 32'd0, $urandom(), $urandom(),
                   32'h0100_0000};
        i_rst_n            = 1'b0;
        mix_shadow         = '0;
        in_if.valid        = 1'b0;
        in_if.sound_number = '0;
        in_if.ear_x        = '0;
        in_if.ear_y        = '0;
        in_if.src_x        = '0;
        in_if.src_y        = '0;
        out_if.ready       = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.master_gain = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // gain still at its reset value
        repeat (60) voice_q.push_back(random_voice());
        wait_idle();

        set_mix(32'h7FFF_FFFF);
        queue_voice(32'h0, 32'h0, 32'h0, 32'h0, 32'h0);
        queue_voice(32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_voice(32'h1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        queue_voice(32'h2, 1000, -20, 1000 + 511, -20);
        queue_voice(32'h3, 1000, -20, 1000 - 512, -20);
        queue_voice(32'h4, 0, 0, 362, 362);
        queue_voice(32'h5, 0, 0, -363, 363);
        queue_voice(32'h6, 0, 0, 46340, 0);
        queue_voice(32'h7, 0, 0, 0, 46341);
        queue_voice(32'h8, 0, 0, 32768, 32768);
        queue_voice(32'h9, 5, 5, 5 + 32'h0001_0000, 5);
        queue_voice(32'hA, 0, 0, 32'h0200_0000, 0);
        queue_voice(32'hB, 0, 0, 32'h01FF_FFFF, 0);
        queue_voice(32'hC, 0, 0, -32'h01FF_FFFF, 0);
        queue_voice(32'hD, 0, 0, 3, 0);
        queue_voice(32'hE, 0, 0, 4, 0);
        queue_voice(32'hF, 0, 0, -4, 0);
        queue_voice(32'h10, -7, 9, -7 + 300, 9 - 400);
        queue_voice(32'h11, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        repeat (100) voice_q.push_back(random_voice());
        wait_idle();

        foreach (levels[i]) begin
            set_mix(levels[i]);
            repeat (75) voice_q.push_back(random_voice());
            wait_idle();
        end

        if (failed)
            $display("tb: failure");
        else
            $display("tb: success");
        $finish;
    end

endmodule
